// ----- rtl/core/tods_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constant arithmetic for the time-of-day sync counter.
package tods_pkg;

  // Item modes
  typedef enum logic [2:0] {
    MODE_TICK = 3'd0,
    MODE_SYNC = 3'd1,
    MODE_HOST = 3'd2,
    MODE_READ = 3'd3,
    MODE_SET  = 3'd4
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_BELOW     = 2'd2,
    ST_NO_SYNC   = 2'd3
  } status_t;

  localparam logic [19:0] MICROS_MAX  = 20'd999999;
  localparam logic [19:0] THR_RESET   = 20'd500;
  localparam logic [10:0] HALF_LAST   = 11'd1999;
  localparam logic [10:0] MS_PER_S    = 11'd1000;
  localparam logic [9:0]  HALF_MS_US  = 10'd500;
  // ceil(2^30 / 1000): exact floor(x / 1000) for any 20-bit x
  localparam logic [40:0] RECIP_1000  = 41'd1073742;

  // Input word after the split stages: microseconds as milliseconds + remainder
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] seconds;
    logic [9:0]  ms;
    logic [9:0]  rem;
  } item_t;

  // Correction threshold, split the same way
  typedef struct packed {
    logic [10:0] ms;
    logic [9:0]  rem;
  } thr_t;

  // Time and status after one word's step
  typedef struct packed {
    logic [31:0] seconds;
    logic [10:0] half;
    status_t     status;
  } res_t;

  // Quotient of a 20-bit value by 1000
  function automatic logic [10:0] div1000(input logic [19:0] x);
    logic [40:0] p;
    p = {21'b0, x} * RECIP_1000;
    return p[40:30];
  endfunction

  // Product of a quotient and 1000 by shift and subtract
  function automatic logic [19:0] times1000(input logic [10:0] q);
    logic [20:0] t;
    t = {q, 10'b0} - {6'b0, q, 4'b0} - {7'b0, q, 3'b0};
    return t[19:0];
  endfunction

endpackage

// ----- rtl/core/time_of_day_sync_counter.sv -----
`timescale 1ns / 1ps
// Time-of-day counter with host offset sync: top level.
// A word passes through the input stage, the split stage and the result register to out_valid.
// Throughput: one word per cycle while out is not held stalled; the state update in tods_core is combinational.
// A stalled output freezes the whole pipeline; in_stall rises only while out is held.
// Reset (synchronous, rst_n low): time, sync latch and pending flag clear; threshold is 500 us.
module time_of_day_sync_counter import tods_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_host_seconds,
  input  logic [19:0] in_host_micros,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_now_seconds,
  output logic [19:0] out_now_micros,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_correction_threshold_us
);

  logic        adv;
  logic        s2_valid;
  item_t       s2_item;
  thr_t        thr;
  res_t        res;
  logic        out_valid_r;
  logic [31:0] out_seconds_r;
  logic [10:0] out_half_r;
  status_t     out_status_r;
  logic [20:0] micros_w;

  // Advance unless a result waits on a stalled output
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign cfg_ready = 1'b1;

  tods_thresh u_thresh (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_correction_threshold_us),
    .thr      (thr)
  );

  tods_split u_split (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_valid),
    .in_mode         (in_mode),
    .in_host_seconds (in_host_seconds),
    .in_host_micros  (in_host_micros),
    .s2_valid        (s2_valid),
    .s2_item         (s2_item)
  );

  tods_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (adv && s2_valid),
    .item   (s2_item),
    .thr    (thr),
    .res    (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      out_seconds_r <= res.seconds;
      out_half_r    <= res.half;
      out_status_r  <= res.status;
    end
  end

  // Half-millisecond count times 500
  assign micros_w = {1'b0, out_half_r, 9'b0} - {7'b0, out_half_r, 3'b0}
                  - {8'b0, out_half_r, 2'b0};

  assign out_valid       = out_valid_r;
  assign out_now_seconds = out_seconds_r;
  assign out_now_micros  = micros_w[19:0];
  assign out_status      = out_status_r;

  // Half-ms count stays in range on every result
  a_half_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_half_r <= HALF_LAST)
    else $error("half-ms count out of range");

  // Only a host timestamp reports a non-zero status
  a_status_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_valid && (s2_item.mode != MODE_HOST)) |=> out_status_r == ST_NONE)
    else $error("non-zero status for a word other than host timestamp");

  // A correction reloads the counter on a whole millisecond
  a_corr_even: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_CORRECTED)) |-> !out_half_r[0])
    else $error("corrected time not on a millisecond boundary");

endmodule

// ----- rtl/core/tods_thresh.sv -----
`timescale 1ns / 1ps
// Correction threshold register, kept split into milliseconds and remainder.
module tods_thresh import tods_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [19:0] cfg_data,
  output thr_t        thr
);

  logic [19:0] raw_r;
  logic [10:0] ms_r;
  logic [9:0]  rem_r;
  logic [19:0] rem_nxt;

  // Remainder is taken from the registered quotient, so it settles in the cycle after the quotient
  assign rem_nxt = raw_r - times1000(ms_r);

  // Capture a write and split it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r <= THR_RESET;
      ms_r  <= '0;
      rem_r <= THR_RESET[9:0];
    end else begin
      if (cfg_we) begin
        raw_r <= cfg_data;
        ms_r  <= div1000(cfg_data);
      end
      rem_r <= rem_nxt[9:0];
    end
  end

  assign thr.ms  = ms_r;
  assign thr.rem = rem_r;

endmodule

// ----- rtl/core/tods_split.sv -----
`timescale 1ns / 1ps
// Input register and front stages: clamp microseconds, split into ms and remainder.
module tods_split import tods_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_host_seconds,
  input  logic [19:0] in_host_micros,
  output logic        s2_valid,
  output item_t       s2_item
);

  logic        s1_valid_r;
  logic [2:0]  s1_mode_r;
  logic [31:0] s1_sec_r;
  logic [19:0] s1_us_r;
  logic [9:0]  s1_ms_r;
  logic [19:0] us_clamp;
  logic [10:0] ms_nxt;
  logic        s2_valid_r;
  item_t       s2_item_r;
  logic [19:0] rem_nxt;

  // Clamp microseconds and take the millisecond quotient
  assign us_clamp = (in_host_micros > MICROS_MAX) ? MICROS_MAX : in_host_micros;
  assign ms_nxt   = div1000(us_clamp);

  // Remainder below one millisecond
  assign rem_nxt = s1_us_r - times1000({1'b0, s1_ms_r});

  // Valid bits move only when the pipeline advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode_r         <= in_mode;
      s1_sec_r          <= in_host_seconds;
      s1_us_r           <= us_clamp;
      s1_ms_r           <= ms_nxt[9:0];
      s2_item_r.mode    <= s1_mode_r;
      s2_item_r.seconds <= s1_sec_r;
      s2_item_r.ms      <= s1_ms_r;
      s2_item_r.rem     <= rem_nxt[9:0];
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_item  = s2_item_r;

endmodule

// ----- rtl/core/tods_core.sv -----
`timescale 1ns / 1ps
// Time-of-day state and the per-word update: tick, sync latch, correction, set.
module tods_core import tods_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  commit,
  input  item_t item,
  input  thr_t  thr,
  output res_t  res
);

  logic [31:0] sec_r, sec_nxt;
  logic [10:0] half_r, half_nxt;
  logic [31:0] sync_sec_r, sync_sec_nxt;
  logic [10:0] sync_half_r, sync_half_nxt;
  logic        sync_wait_r, sync_wait_nxt;
  status_t     status;

  logic [9:0]  sm;
  logic        br1;
  logic [9:0]  dr;
  logic [10:0] sub_sm;
  logic        borrow;
  logic [10:0] dm_w;
  logic [9:0]  dm;
  logic [31:0] dsec;
  logic        below;
  logic [10:0] odd_add;
  logic        c2;
  logic [10:0] ms_tot;
  logic        carry;
  logic [10:0] ms_new;
  logic [31:0] sec_sum;

  // Offset host minus latched time, in ms + remainder, with borrows
  always_comb begin
    sm      = sync_half_r[10:1];
    br1     = sync_half_r[0] && (item.rem < HALF_MS_US);
    if (!sync_half_r[0]) begin
      dr = item.rem;
    end else if (br1) begin
      dr = item.rem + HALF_MS_US;
    end else begin
      dr = item.rem - HALF_MS_US;
    end
    sub_sm  = {1'b0, sm} + {10'b0, br1};
    borrow  = {1'b0, item.ms} < sub_sm;
    dm_w    = borrow ? ({1'b0, item.ms} + MS_PER_S - sub_sm) : ({1'b0, item.ms} - sub_sm);
    dm      = dm_w[9:0];
    dsec    = item.seconds - sync_sec_r - {31'b0, borrow};
    below   = (dsec == 32'd0) &&
              (({1'b0, dm} < thr.ms) || (({1'b0, dm} == thr.ms) && (dr < thr.rem)));
  end

  // Add the offset to the current time, carrying into milliseconds and into seconds
  always_comb begin
    odd_add = (half_r[0] ? {1'b0, HALF_MS_US} : 11'd0) + {1'b0, dr};
    c2      = odd_add >= MS_PER_S;
    ms_tot  = {1'b0, half_r[10:1]} + {1'b0, dm} + {10'b0, c2};
    carry   = ms_tot >= MS_PER_S;
    ms_new  = carry ? (ms_tot - MS_PER_S) : ms_tot;
    sec_sum = sec_r + dsec + {31'b0, carry};
  end

  // Decode the mode and pick next state
  always_comb begin
    sec_nxt       = sec_r;
    half_nxt      = half_r;
    sync_sec_nxt  = sync_sec_r;
    sync_half_nxt = sync_half_r;
    sync_wait_nxt = sync_wait_r;
    status        = ST_NONE;
    unique case (item.mode)
      MODE_TICK: begin
        if (half_r >= HALF_LAST) begin
          half_nxt = '0;
          sec_nxt  = sec_r + 32'd1;
        end else begin
          half_nxt = half_r + 11'd1;
        end
      end
      MODE_SYNC: begin
        sync_sec_nxt  = sec_r;
        sync_half_nxt = half_r;
        sync_wait_nxt = 1'b1;
      end
      MODE_HOST: begin
        if (!sync_wait_r) begin
          status = ST_NO_SYNC;
        end else begin
          sync_wait_nxt = 1'b0;
          if (below) begin
            status = ST_BELOW;
          end else begin
            sec_nxt  = sec_sum;
            half_nxt = {ms_new[9:0], 1'b0};
            status   = ST_CORRECTED;
          end
        end
      end
      MODE_SET: begin
        sec_nxt  = item.seconds;
        half_nxt = {item.ms, 1'b0};
      end
      MODE_READ: ;
      // unused codes behave as a read
      default: ;
    endcase
  end

  // Commit state when a word leaves for the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r       <= '0;
      half_r      <= '0;
      sync_sec_r  <= '0;
      sync_half_r <= '0;
      sync_wait_r <= 1'b0;
    end else if (commit) begin
      sec_r       <= sec_nxt;
      half_r      <= half_nxt;
      sync_sec_r  <= sync_sec_nxt;
      sync_half_r <= sync_half_nxt;
      sync_wait_r <= sync_wait_nxt;
    end
  end

  assign res.seconds = sec_nxt;
  assign res.half    = half_nxt;
  assign res.status  = status;

endmodule

// ----- sim/tod_checker.sv -----
`timescale 1ns / 1ps
// Watches the time-of-day counter channels, predicts each reading and compares it.
module tod_checker import tods_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_host_seconds,
  input  logic [19:0] in_host_micros,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_now_seconds,
  input  logic [19:0] out_now_micros,
  input  logic [1:0]  out_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [19:0] cfg_correction_threshold_us,
  output int unsigned mismatch_count,
  output int unsigned readings_waiting
);

  localparam int unsigned USEC_PER_SEC     = 1000000;
  localparam int unsigned USEC_PER_MS      = 1000;
  localparam int unsigned USEC_PER_HALF_MS = 500;

  typedef struct packed {
    logic [31:0] secs;
    logic [19:0] micros;
    status_t     status;
  } tod_reading_t;

  // Shadow of the block's time, sync latch and threshold
  logic [31:0] tod_secs;
  logic [10:0] tod_half;
  logic [31:0] latched_secs;
  logic [19:0] latched_us;
  logic        sync_armed;
  logic [19:0] threshold_us;

  tod_reading_t expected_readings[$];

  // Load time from seconds and microseconds, truncating to whole milliseconds
  function automatic void load_tod(input logic [31:0] secs, input int unsigned usec);
    tod_secs = secs;
    tod_half = 11'((usec / USEC_PER_MS) * 2);
  endfunction

  // Advance the shadow state by one word and return the reading it yields
  function automatic tod_reading_t apply_word(input logic [2:0] mode,
                                              input logic [31:0] host_secs,
                                              input logic [19:0] host_us);
    int unsigned  hu;
    int unsigned  dus;
    int unsigned  sum_us;
    logic [31:0]  dsec;
    logic [31:0]  sum_secs;
    tod_reading_t r;
    hu = (host_us > MICROS_MAX) ? int'(MICROS_MAX) : int'(host_us);
    r.status = ST_NONE;
    case (mode)
      MODE_TICK: begin
        if (tod_half >= HALF_LAST) begin
          tod_half = '0;
          tod_secs = tod_secs + 32'd1;
        end else begin
          tod_half = tod_half + 11'd1;
        end
      end
      MODE_SYNC: begin
        latched_secs = tod_secs;
        latched_us   = 20'(int'(tod_half) * USEC_PER_HALF_MS);
        sync_armed   = 1'b1;
      end
      MODE_HOST: begin
        if (!sync_armed) begin
          r.status = ST_NO_SYNC;
        end else begin
          sync_armed = 1'b0;
          dsec = host_secs - latched_secs;
          // borrow a second when the host microseconds trail the latch
          if (hu < latched_us) begin
            dsec = dsec - 32'd1;
            dus  = hu + USEC_PER_SEC - latched_us;
          end else begin
            dus  = hu - latched_us;
          end
          if (dsec == 32'd0 && dus < threshold_us) begin
            r.status = ST_BELOW;
          end else begin
            sum_secs = tod_secs + dsec;
            sum_us   = int'(tod_half) * USEC_PER_HALF_MS + dus;
            if (sum_us >= USEC_PER_SEC) begin
              sum_secs = sum_secs + 32'd1;
              sum_us   = sum_us - USEC_PER_SEC;
            end
            load_tod(sum_secs, sum_us);
            r.status = ST_CORRECTED;
          end
        end
      end
      MODE_SET: load_tod(host_secs, hu);
      default: ;  // read and unused modes leave the time alone
    endcase
    r.secs   = tod_secs;
    r.micros = 20'(int'(tod_half) * USEC_PER_HALF_MS);
    return r;
  endfunction

  // Compare finished readings, then predict the word taken at this edge
  always @(posedge clk) begin
    tod_reading_t want;
    if (!rst_n) begin
      tod_secs     = '0;
      tod_half     = '0;
      latched_secs = '0;
      latched_us   = '0;
      sync_armed   = 1'b0;
      threshold_us = THR_RESET;
      expected_readings.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: reading with no word pending: seconds %0d micros %0d status %0d",
                   $time, out_now_seconds, out_now_micros, out_status);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = expected_readings.pop_front();
          if (out_now_seconds !== want.secs) begin
            $display("%0t: now_seconds expected %0d, got %0d",
                     $time, want.secs, out_now_seconds);
            mismatch_count = mismatch_count + 1;
          end
          if (out_now_micros !== want.micros) begin
            $display("%0t: now_micros expected %0d, got %0d",
                     $time, want.micros, out_now_micros);
            mismatch_count = mismatch_count + 1;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, out_status);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_readings.push_back(apply_word(in_mode, in_host_seconds, in_host_micros));
      if (cfg_valid && cfg_ready)
        threshold_us = cfg_correction_threshold_us;
    end
    readings_waiting = expected_readings.size();
  end

endmodule

// ----- sim/time_of_day_sync_counter_test.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the time-of-day sync counter, with the checker beside it.
module time_of_day_sync_counter_test;
  import tods_pkg::*;

  localparam int          PIPE_LATENCY  = 3;
  localparam int unsigned PHASE_WORDS   = 210;
  localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
  localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
  localparam longint      USEC_PER_SEC  = 1000000;
  localparam longint      USEC_HALF_MS  = 500;
  localparam longint      HALF_PER_SEC  = 2000;
  localparam longint      STAMP_SPAN    = 64'd4294967296 * 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_mode;
  logic [31:0] in_host_seconds;
  logic [19:0] in_host_micros;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_now_seconds;
  logic [19:0] out_now_micros;
  logic [1:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [19:0] cfg_correction_threshold_us;

  int unsigned mismatch_count;
  int unsigned readings_waiting;
  int unsigned words_sent;
  int          send_idle_pct;
  int          stall_pct;
  logic [19:0] threshold_now;

  time_of_day_sync_counter uut (.*);

  tod_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #2000000;
    $display("** time_of_day_sync_counter: FAILED **");
    $finish;
  end

  // Receiver stalls at the phase's rate
  always @(negedge clk)
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);

  function automatic logic [19:0] rand_micros();
    logic [19:0] v;
    if ($urandom_range(9) == 0) v = 20'($urandom_range(1048575, 1000000));
    else v = 20'($urandom_range(999999, 0));
    return v;
  endfunction

  // Offer one word after an optional idle gap and hold it until taken
  task automatic send_word(input logic [2:0] mode, input logic [31:0] secs,
                           input logic [19:0] usec);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_host_seconds <= secs;
    in_host_micros  <= usec;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and wait until every reading is back and the pipe is empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (readings_waiting != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 1) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [19:0] value);
    @(negedge clk);
    cfg_valid                   <= 1'b1;
    cfg_correction_threshold_us <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    threshold_now = value;
  endtask

  // Mostly set, ticks, sync, more words, then a host stamp near or far from the latched time
  task automatic run_sequence();
    int unsigned pick;
    int unsigned shape;
    int          half;
    longint      base;
    longint      stamp;
    logic [31:0] set_secs;
    logic [19:0] set_us;
    logic [2:0]  filler;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(4, 1))
        send_word(3'($urandom_range(MODE_SPARE_HI, MODE_TICK)), $urandom, rand_micros());
      return;
    end
    set_secs = $urandom;
    set_us   = rand_micros();
    send_word(MODE_SET, set_secs, set_us);
    half = ((set_us > MICROS_MAX ? MICROS_MAX : set_us) / 1000) * 2;
    repeat ($urandom_range(6, 0)) begin
      send_word(MODE_TICK, $urandom, rand_micros());
      half++;
    end
    base = set_secs + half / HALF_PER_SEC;
    half = int'(half % HALF_PER_SEC);
    // leave the sync out now and then
    if (pick >= 18) send_word(MODE_SYNC, $urandom, rand_micros());
    repeat ($urandom_range(3, 0)) begin
      case ($urandom_range(3))
        0: filler = MODE_READ;
        1: filler = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
        default: filler = MODE_TICK;
      endcase
      send_word(filler, $urandom, rand_micros());
    end
    shape = $urandom_range(9);
    stamp = base * USEC_PER_SEC + half * USEC_HALF_MS;
    if (shape < 5) stamp = stamp + $urandom_range(2 * threshold_now + 4, 0);
    else if (shape < 7) stamp = stamp - longint'($urandom_range(3000000, 1));
    else stamp = stamp + longint'($urandom) * 1000;
    if (stamp < 0) stamp = stamp + STAMP_SPAN;
    if (stamp >= STAMP_SPAN) stamp = stamp - STAMP_SPAN;
    if (shape == 9) send_word(MODE_HOST, $urandom, rand_micros());
    else send_word(MODE_HOST, 32'(stamp / USEC_PER_SEC), 20'(stamp % USEC_PER_SEC));
    // a second stamp finds the sync already consumed
    if (pick >= 90) send_word(MODE_HOST, $urandom, rand_micros());
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [19:0] thr);
    int unsigned goal;
    drain();
    write_threshold(thr);
    send_idle_pct = idle;
    stall_pct     = stall;
    goal = words_sent + PHASE_WORDS;
    while (words_sent < goal) begin
      // hold off until everything is back once in a while
      if ($urandom_range(29) == 0) drain();
      run_sequence();
    end
  endtask

  initial begin
    rst_n                       = 1'b0;
    in_valid                    = 1'b0;
    in_mode                     = MODE_READ;
    in_host_seconds             = '0;
    in_host_micros              = '0;
    cfg_valid                   = 1'b0;
    cfg_correction_threshold_us = '0;
    out_stall                   = 1'b0;
    words_sent                  = 0;
    send_idle_pct               = 0;
    stall_pct                   = 0;
    threshold_now               = THR_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset threshold, wraps, saturation, borrow, carry, unused modes
    send_word(MODE_READ, 32'hFFFF_FFFF, 20'hFFFFF);
    send_word(MODE_TICK, '0, '0);
    send_word(MODE_TICK, '0, '0);
    send_word(MODE_HOST, 32'd5, 20'd10);
    send_word(MODE_SET, 32'hFFFF_FFFF, MICROS_MAX);
    send_word(MODE_TICK, '0, '0);
    send_word(MODE_TICK, '0, '0);
    send_word(MODE_SET, 32'd100, 20'hFFFFF);
    send_word(MODE_SYNC, '0, '0);
    send_word(MODE_HOST, 32'd100, 20'd999100);
    send_word(MODE_HOST, 32'd100, 20'd999100);
    send_word(MODE_SYNC, '0, '0);
    send_word(MODE_HOST, 32'd101, 20'd0);
    send_word(MODE_SPARE_LO, 32'hA5A5_A5A5, 20'h5A5A5);
    send_word(MODE_SPARE_LO + 3'd1, 32'h5A5A_5A5A, 20'hA5A5A);
    send_word(MODE_SPARE_HI, 32'hFFFF_FFFF, 20'hFFFFF);
    send_word(MODE_SET, '0, '0);
    send_word(MODE_SYNC, '0, '0);
    send_word(MODE_HOST, 32'hFFFF_FFFF, 20'd0);
    send_word(MODE_TICK, '0, '0);
    send_word(MODE_SYNC, '0, '0);
    send_word(MODE_HOST, 32'hFFFF_FFFF, 20'd1000);
    send_word(MODE_HOST, '0, '0);
    send_word(MODE_SYNC, '0, '0);
    send_word(MODE_HOST, 32'hFFFF_FFFF, 20'hFFFFF);

    run_phase(0, 0, 20'd0);
    run_phase(83, 0, MICROS_MAX);
    run_phase(0, 83, 20'($urandom_range(999999, 0)));
    run_phase(28, 28, THR_RESET);

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && readings_waiting == 0) begin
      $display("** time_of_day_sync_counter: PASSED **");
    end else begin
      $display("** time_of_day_sync_counter: FAILED **");
    end
    $finish;
  end

endmodule
